@@ hw/rtl/ipat_pkg.sv @@
// Shared types, codes and character helpers for the address-to-text block.
package ipat_pkg;

  // Address family codes carried in the opcode field.
  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  // Status codes on each output word.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SMALL  = 2'd1;
  localparam logic [1:0] ST_FAMILY = 2'd2;

  // Text buffer sizing: the longest text is 39 characters.
  localparam int TEXT_DEPTH = 40;
  localparam int PTR_W      = $clog2(TEXT_DEPTH + 1);

  // ASCII characters used by the formatter.
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;

  // Request to the character unit: a hex word or a decimal byte, and a digit place.
  typedef struct packed {
    logic        is_dec;
    logic [15:0] value;
    logic [1:0]  sel;
  } char_req_t;

  // Response: the ASCII digit and whether it is printed (leading zeros are not).
  typedef struct packed {
    logic [7:0] ch;
    logic       show;
  } char_rsp_t;

  // Lowercase hex digit to ASCII.
  function automatic logic [7:0] hex_ascii(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'b0000, d};
    end else begin
      r = CH_A + {4'b0000, d - 4'd10};
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ipat_char_unit.sv @@
// Shared digit unit: one hex nibble or one decimal digit of a byte per request.
module ipat_char_unit (
  input  ipat_pkg::char_req_t req,
  output ipat_pkg::char_rsp_t rsp
);

  logic [15:0] shifted;
  logic [7:0]  v;
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [3:0]  tens;
  logic [6:0]  ones7;
  logic [3:0]  digit;

  // Hex place: shift the word down to the selected nibble.
  assign shifted = req.value >> {req.sel, 2'b00};

  // Decimal split of a byte: hundreds by compare, tens by a compare ladder.
  always_comb begin
    v = req.value[7:0];
    if (v >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(v - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = v[6:0];
    end
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 7'(k * 10)) begin
        tens = 4'(k);
      end
    end
    ones7 = rem - 7'(tens) * 7'd10;
  end

  // Pick the digit and decide whether it is a suppressed leading zero.
  always_comb begin
    digit = 4'd0;
    rsp   = '0;
    if (req.is_dec) begin
      case (req.sel)
        2'd2: begin
          digit    = {2'b00, hund};
          rsp.show = (v >= 8'd100);
        end
        2'd1: begin
          digit    = tens;
          rsp.show = (v >= 8'd10);
        end
        default: begin
          digit    = ones7[3:0];
          rsp.show = 1'b1;
        end
      endcase
      rsp.ch = ipat_pkg::CH_ZERO + {4'b0000, digit};
    end else begin
      digit    = shifted[3:0];
      rsp.show = (shifted != 16'd0) || (req.sel == 2'd0);
      rsp.ch   = ipat_pkg::hex_ascii(digit);
    end
  end

endmodule

@@ hw/rtl/ip_address_to_text_top.sv @@
// Top level: formats an IPv4 or IPv6 address as text, one character per output word.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------------
//   in      | in_valid / in_stall    | opcode, addr_high, addr_low, buffer_size
//   out     | out_valid / out_stall  | text_char, last, status
//
// An address is taken only while the formatter is idle, and in_stall stays high
// until its last word has been loaded into the output register.
// IPv6 first scans the eight words for the longest zero run, settles the run, then
// formats each hex word through the shared digit unit, and reads the text out
// character by character through the single read port of the text buffer.
// IPv4 builds its dotted text through the same digit unit and is read out the same way.
// An unsupported family goes from idle to the error state and then to the output
// register; a buffer that is too small is found once the text has been built.
// A stall on out holds the read-out in place.
// rst is synchronous and returns the block to idle with no output word pending.
module ip_address_to_text_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  input  logic [7:0]  buffer_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  text_char,
  output logic        last,
  output logic [1:0]  status
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_FIX   = 4'd2;
  localparam logic [3:0] S_WORD  = 4'd3;
  localparam logic [3:0] S_HEX   = 4'd4;
  localparam logic [3:0] S_QUAD  = 4'd5;
  localparam logic [3:0] S_DOT   = 4'd6;
  localparam logic [3:0] S_TAIL  = 4'd7;
  localparam logic [3:0] S_CHECK = 4'd8;
  localparam logic [3:0] S_RD    = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_ERR   = 4'd11;

  localparam int PW = ipat_pkg::PTR_W;
  localparam logic [PW-1:0] PTR_ONE = PW'(1);

  logic [3:0]    state;
  logic [127:0]  addr;
  logic [7:0]    size;
  logic [31:0]   quad;
  logic [2:0]    idx;
  logic [1:0]    sel;
  logic [1:0]    qb;
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic          cur_valid;
  logic [2:0]    cur_base;
  logic [3:0]    cur_len;
  logic          best_valid;
  logic [2:0]    best_base;
  logic [3:0]    best_len;
  logic [1:0]    err_code;
  logic [7:0]    rdata;
  logic [7:0]    text_mem [ipat_pkg::TEXT_DEPTH];

  logic [15:0]   word;
  logic [15:0]   word5;
  logic [7:0]    qbyte;
  logic [3:0]    run_end;
  logic          in_run;
  logic          embed;
  logic          merge_take;
  logic          slot_free;
  logic          out_load;
  logic          wr_en;
  logic [7:0]    wr_char;

  ipat_pkg::char_req_t req;
  ipat_pkg::char_rsp_t rsp;

  ipat_char_unit u_char (
    .req (req),
    .rsp (rsp)
  );

  // Address words, run bounds and the embedded IPv4 test.
  assign word       = 16'(addr >> {~idx, 4'b0000});
  assign word5      = addr[47:32];
  assign qbyte      = 8'(quad >> {~qb, 3'b000});
  assign run_end    = {1'b0, best_base} + best_len;
  assign in_run     = best_valid && ({1'b0, idx} >= {1'b0, best_base}) &&
                      ({1'b0, idx} < run_end);
  assign embed      = best_valid && (best_base == 3'd0) &&
                      ((best_len == 4'd6) || ((best_len == 4'd5) && (word5 == 16'hffff)));
  assign merge_take = cur_valid && (!best_valid || (cur_len > best_len));
  assign slot_free  = !out_valid || !out_stall;
  assign out_load   = slot_free && ((state == S_OUT) || (state == S_ERR));
  assign in_stall   = (state != S_IDLE);

  // Request to the shared digit unit.
  always_comb begin
    req.is_dec = (state == S_QUAD);
    req.value  = (state == S_QUAD) ? {8'd0, qbyte} : word;
    req.sel    = sel;
  end

  // Character written to the text buffer in this cycle.
  always_comb begin
    wr_en   = 1'b0;
    wr_char = ipat_pkg::CH_COLON;
    unique case (state)
      S_WORD: begin
        if (in_run) begin
          wr_en = (idx == best_base);
        end else begin
          wr_en = (idx != 3'd0);
        end
      end
      S_HEX, S_QUAD: begin
        wr_en   = rsp.show;
        wr_char = rsp.ch;
      end
      S_DOT: begin
        wr_en   = 1'b1;
        wr_char = ipat_pkg::CH_DOT;
      end
      S_TAIL: begin
        wr_en = best_valid && (run_end == 4'd8);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Text buffer: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      text_mem[wptr] <= wr_char;
    end
    rdata <= text_mem[rptr];
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        wptr <= wptr + PTR_ONE;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            addr       <= {addr_high, addr_low};
            size       <= buffer_size;
            wptr       <= '0;
            idx        <= 3'd0;
            cur_valid  <= 1'b0;
            best_valid <= 1'b0;
            quad       <= addr_high[63:32];
            qb         <= 2'd0;
            sel        <= 2'd2;
            if (opcode == ipat_pkg::FAM_V4) begin
              state <= S_QUAD;
            end else if (opcode == ipat_pkg::FAM_V6) begin
              state <= S_SCAN;
            end else begin
              err_code <= ipat_pkg::ST_FAMILY;
              state    <= S_ERR;
            end
          end
        end
        S_SCAN: begin
          if (word == 16'd0) begin
            if (cur_valid) begin
              cur_len <= cur_len + 4'd1;
            end else begin
              cur_valid <= 1'b1;
              cur_base  <= idx;
              cur_len   <= 4'd1;
            end
          end else if (cur_valid) begin
            if (merge_take) begin
              best_valid <= 1'b1;
              best_base  <= cur_base;
              best_len   <= cur_len;
            end
            cur_valid <= 1'b0;
          end
          idx <= idx + 3'd1;
          if (idx == 3'd7) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          // Close a run that reaches the end, then drop runs of one word.
          if (merge_take) begin
            best_base  <= cur_base;
            best_len   <= cur_len;
            best_valid <= (cur_len >= 4'd2);
          end else begin
            best_valid <= best_valid && (best_len >= 4'd2);
          end
          idx   <= 3'd0;
          state <= S_WORD;
        end
        S_WORD: begin
          if (in_run) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              state <= S_TAIL;
            end
          end else if ((idx == 3'd6) && embed) begin
            quad  <= addr[31:0];
            qb    <= 2'd0;
            sel   <= 2'd2;
            state <= S_QUAD;
          end else begin
            sel   <= 2'd3;
            state <= S_HEX;
          end
        end
        S_HEX: begin
          sel <= sel - 2'd1;
          if (sel == 2'd0) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              state <= S_TAIL;
            end else begin
              state <= S_WORD;
            end
          end
        end
        S_QUAD: begin
          sel <= sel - 2'd1;
          if (sel == 2'd0) begin
            if (qb == 2'd3) begin
              state <= S_CHECK;
            end else begin
              state <= S_DOT;
            end
          end
        end
        S_DOT: begin
          qb    <= qb + 2'd1;
          sel   <= 2'd2;
          state <= S_QUAD;
        end
        S_TAIL: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          // The text and its terminator must fit the caller's buffer.
          if ((8'(wptr) + 8'd1) > size) begin
            err_code <= ipat_pkg::ST_SMALL;
            state    <= S_ERR;
          end else begin
            rptr  <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            text_char <= rdata;
            last      <= (rptr == wptr - PTR_ONE);
            status    <= ipat_pkg::ST_OK;
            rptr      <= rptr + PTR_ONE;
            if (rptr == wptr - PTR_ONE) begin
              state <= S_IDLE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_ERR: begin
          if (slot_free) begin
            text_char <= 8'd0;
            last      <= 1'b1;
            status    <= err_code;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The write pointer never runs past the text buffer.
  a_wptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (8'(wptr) <= 8'(ipat_pkg::TEXT_DEPTH)))
    else $error("text buffer write pointer overran");

  // An unsupported family goes straight to the error result.
  a_family_err: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && opcode[1]) |=> (state == S_ERR))
    else $error("unsupported family did not raise an error");

  // An error status always travels on a last word with a zero character.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ipat_pkg::ST_OK)) |-> (last && (text_char == 8'd0)))
    else $error("error word is not a single last word");

  // A kept zero run is at least two words long and ends within the address.
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WORD) && best_valid) |-> ((best_len >= 4'd2) && (run_end <= 4'd8)))
    else $error("zero run bounds are wrong");

  // Read-out only begins with a nonempty text that fits the buffer.
  a_fit: assert property (@(posedge clk) disable iff (rst)
    ((state == S_CHECK) && ((8'(wptr) + 8'd1) <= size)) |=>
    ((state == S_RD) && (wptr != '0)))
    else $error("read-out started on a bad text");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the address-to-text formatter: a directed table, then random addresses.
`timescale 1ns / 1ps

module tb_top;

  // Codes and characters shared with the design.
  localparam logic [1:0] FAM_V4    = ipat_pkg::FAM_V4;
  localparam logic [1:0] FAM_V6    = ipat_pkg::FAM_V6;
  localparam logic [1:0] ST_OK     = ipat_pkg::ST_OK;
  localparam logic [1:0] ST_SMALL  = ipat_pkg::ST_SMALL;
  localparam logic [1:0] ST_FAMILY = ipat_pkg::ST_FAMILY;
  localparam logic [7:0] CH_COLON  = ipat_pkg::CH_COLON;
  localparam logic [7:0] CH_DOT    = ipat_pkg::CH_DOT;
  localparam logic [7:0] CH_ZERO   = ipat_pkg::CH_ZERO;
  localparam logic [7:0] CH_A      = ipat_pkg::CH_A;

  // Families that the block rejects.
  localparam logic [1:0] FAM_SPARE2 = 2'd2;
  localparam logic [1:0] FAM_SPARE3 = 2'd3;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_PER_PHASE = 32;
  // Longest build plus read-out of one address, with margin.
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int PRESSURE_ITEMS = 6;

  // One output word as the block should present it.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [1:0] st;
  } text_word_t;

  // One directed row; typed rows carry their expected text or error status.
  typedef struct {
    logic [1:0]  fam;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  size;
    bit          typed;
    logic [1:0]  st;
    string       text;
  } address_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = FAM_V4;
  logic [63:0] addr_high = '0;
  logic [63:0] addr_low = '0;
  logic [7:0]  buffer_size = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  text_char;
  logic        last;
  logic [1:0]  status;

  text_word_t  expected_words[$];
  logic [7:0]  address_text[$];
  int          mismatches = 0;
  int          words_seen = 0;
  int          send_idle_pct = 34;
  int          recv_idle_pct = 88;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;

  address_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{FAM_V4, 64'h00000000_ffffffff, 64'hffffffff_ffffffff, 8'd8, 1'b1, ST_OK, "0.0.0.0"},
    '{FAM_V4, 64'hffffffff_00000000, 64'h0, 8'd16, 1'b1, ST_OK, "255.255.255.255"},
    '{FAM_V4, 64'hffffffff_00000000, 64'h0, 8'd15, 1'b1, ST_SMALL, ""},
    '{FAM_V4, 64'h01020304_00000000, 64'h0, 8'd0, 1'b1, ST_SMALL, ""},
    '{FAM_V4, 64'h01020304_deadbeef, 64'hffffffff_ffffffff, 8'd255, 1'b1, ST_OK, "1.2.3.4"},
    '{FAM_V4, 64'hc0a80a64_00000000, 64'h0, 8'd255, 1'b1, ST_OK, "192.168.10.100"},
    '{FAM_SPARE2, 64'hffffffff_ffffffff, 64'hffffffff_ffffffff, 8'd255, 1'b1, ST_FAMILY, ""},
    '{FAM_SPARE3, 64'h0, 64'h0, 8'd0, 1'b1, ST_FAMILY, ""},
    '{FAM_V6, 64'h0, 64'h0, 8'd3, 1'b1, ST_OK, "::"},
    '{FAM_V6, 64'h0, 64'h0, 8'd2, 1'b1, ST_SMALL, ""},
    '{FAM_V6, 64'hffffffff_ffffffff, 64'hffffffff_ffffffff, 8'd40, 1'b1, ST_OK,
      "ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff"},
    '{FAM_V6, 64'hffffffff_ffffffff, 64'hffffffff_ffffffff, 8'd39, 1'b1, ST_SMALL, ""},
    '{FAM_V6, 64'h0, 64'h1, 8'd255, 1'b1, ST_OK, "::1"},
    '{FAM_V6, 64'h0001_0000_0000_0000, 64'h0, 8'd255, 1'b1, ST_OK, "1::"},
    '{FAM_V6, 64'h0, 64'h0000_ffff_0102_0304, 8'd255, 1'b1, ST_OK, "::ffff:1.2.3.4"},
    '{FAM_V6, 64'h0, 64'h0000_0000_0102_0304, 8'd255, 1'b1, ST_OK, "::1.2.3.4"},
    // Two equal zero runs, then a single zero word, then a longer later run.
    '{FAM_V6, 64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004, 8'd255, 1'b0, ST_OK, ""},
    '{FAM_V6, 64'h0001_0000_0002_0003, 64'h0004_0005_0006_0007, 8'd255, 1'b0, ST_OK, ""},
    '{FAM_V6, 64'h0001_0000_0000_0002, 64'h0000_0000_0000_0003, 8'd255, 1'b0, ST_OK, ""},
    // Leading zeros inside words.
    '{FAM_V6, 64'h0abc_00de_000f_1000, 64'h0100_0010_0001_f00f, 8'd255, 1'b0, ST_OK, ""},
    // Mapped form with a zero quad, and a near miss on the mapped form.
    '{FAM_V6, 64'h0, 64'h0000_ffff_0000_0000, 8'd255, 1'b0, ST_OK, ""},
    '{FAM_V6, 64'h0, 64'h0000_fffe_0102_0304, 8'd255, 1'b0, ST_OK, ""},
    // Six zero words that do not start the address, and a run at the end.
    '{FAM_V6, 64'h0001_0000_0000_0000, 64'h0000_0000_0000_0002, 8'd255, 1'b0, ST_OK, ""},
    '{FAM_V6, 64'h0001_0002_0003_0004, 64'h0005_0006_0000_0000, 8'd255, 1'b0, ST_OK, ""},
    '{FAM_V6, 64'h2001_0db8_0000_0000, 64'h0000_ff00_0042_8329, 8'd255, 1'b0, ST_OK, ""}
  };

  ip_address_to_text_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .addr_high   (addr_high),
    .addr_low    (addr_low),
    .buffer_size (buffer_size),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .text_char   (text_char),
    .last        (last),
    .status      (status)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void push_word(input logic [7:0] ch, input logic fin, input logic [1:0] st);
    text_word_t w;
    w.ch = ch;
    w.last = fin;
    w.st = st;
    expected_words.push_back(w);
  endfunction

  // Appends a 32-bit address in dotted decimal to the text under construction.
  function automatic void append_dotted(input logic [31:0] quad);
    logic [7:0] v;
    for (int b = 3; b >= 0; b--) begin
      v = quad[b*8 +: 8];
      if (v >= 8'd100) address_text.push_back(CH_ZERO + v / 8'd100);
      if (v >= 8'd10) address_text.push_back(CH_ZERO + (v / 8'd10) % 8'd10);
      address_text.push_back(CH_ZERO + v % 8'd10);
      if (b != 0) address_text.push_back(CH_DOT);
    end
  endfunction

  // Builds the presentation text of an IPv6 address, with zero-run compression.
  function automatic void append_v6(input logic [63:0] hi, input logic [63:0] lo);
    logic [15:0] w [8];
    logic [3:0]  d;
    logic        started;
    int          best_base, best_len, run_base, run_len;
    best_base = -1;
    best_len = 0;
    run_base = -1;
    run_len = 0;
    for (int i = 0; i < 8; i++) begin
      w[i] = (i < 4) ? hi[(3-i)*16 +: 16] : lo[(7-i)*16 +: 16];
    end

    // Find the longest zero run; a later run must be strictly longer to win.
    for (int i = 0; i < 8; i++) begin
      if (w[i] == 16'h0) begin
        if (run_base < 0) begin
          run_base = i;
          run_len = 1;
        end else begin
          run_len++;
        end
      end else if (run_base >= 0) begin
        if (best_base < 0 || run_len > best_len) begin
          best_base = run_base;
          best_len = run_len;
        end
        run_base = -1;
      end
    end
    if (run_base >= 0 && (best_base < 0 || run_len > best_len)) begin
      best_base = run_base;
      best_len = run_len;
    end
    if (best_len < 2) best_base = -1;

    // Emit the words, collapsing the chosen run and switching to a dotted tail if mapped.
    for (int i = 0; i < 8; i++) begin
      if (best_base >= 0 && i >= best_base && i < best_base + best_len) begin
        if (i == best_base) address_text.push_back(CH_COLON);
        continue;
      end
      if (i != 0) address_text.push_back(CH_COLON);
      if (i == 6 && best_base == 0 &&
          (best_len == 6 || (best_len == 5 && w[5] == 16'hffff))) begin
        append_dotted(lo[31:0]);
        return;
      end
      started = 1'b0;
      for (int s = 3; s >= 0; s--) begin
        d = w[i][s*4 +: 4];
        if (d != 4'h0 || started || s == 0) begin
          address_text.push_back((d < 4'd10) ? CH_ZERO + {4'b0000, d}
                                             : CH_A + {4'b0000, d} - 8'd10);
          started = 1'b1;
        end
      end
    end
    if (best_base >= 0 && best_base + best_len == 8) address_text.push_back(CH_COLON);
  endfunction

  // Text of a supported address, left in address_text.
  function automatic void build_text(input logic [1:0] fam, input logic [63:0] hi,
                                     input logic [63:0] lo);
    address_text.delete();
    if (fam == FAM_V4) append_dotted(hi[63:32]);
    else append_v6(hi, lo);
  endfunction

  // Queues the words that one accepted address should produce.
  function automatic void predict_words(input logic [1:0] fam, input logic [63:0] hi,
                                        input logic [63:0] lo, input logic [7:0] size);
    int n;
    if (fam != FAM_V4 && fam != FAM_V6) begin
      push_word(8'h00, 1'b1, ST_FAMILY);
      return;
    end
    build_text(fam, hi, lo);
    n = address_text.size();
    if (n + 1 > int'(size)) begin
      push_word(8'h00, 1'b1, ST_SMALL);
    end else begin
      for (int k = 0; k < n; k++) push_word(address_text[k], k == n - 1, ST_OK);
    end
  endfunction

  // Offers one address, with random idle cycles first, and returns once it is taken.
  task automatic send_address(input logic [1:0] fam, input logic [63:0] hi,
                              input logic [63:0] lo, input logic [7:0] size);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= fam;
    addr_high <= hi;
    addr_low <= lo;
    buffer_size <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drops valid and waits for every queued word, plus the block's latency.
  task automatic drain_words();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] random_v6_word();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 16'h0;
    if (r < 50) return 16'hffff;
    return 16'($urandom) & (16'hffff >> (4 * $urandom_range(3)));
  endfunction

  function automatic logic [7:0] random_v4_byte();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 8'($urandom_range(9));
    if (r < 60) return 8'($urandom_range(99));
    return 8'($urandom_range(255));
  endfunction

  // Draws one random address, biased toward zero runs and mapped forms, and sends it.
  task automatic send_random_address();
    logic [1:0]  fam;
    logic [63:0] hi, lo;
    logic [7:0]  size;
    logic [15:0] w [8];
    int          r, n;
    r = $urandom_range(99);
    hi = {$urandom, $urandom};
    lo = {$urandom, $urandom};
    if (r < 10) begin
      fam = $urandom_range(1) ? FAM_SPARE2 : FAM_SPARE3;
    end else if (r < 40) begin
      fam = FAM_V4;
      hi[63:32] = {random_v4_byte(), random_v4_byte(), random_v4_byte(), random_v4_byte()};
    end else begin
      fam = FAM_V6;
      r = $urandom_range(99);
      if (r >= 25) begin
        for (int i = 0; i < 8; i++) w[i] = random_v6_word();
        if (r < 45) begin
          for (int i = 0; i < 5; i++) w[i] = 16'h0;
          w[5] = $urandom_range(1) ? 16'hffff : 16'h0;
        end
        hi = {w[0], w[1], w[2], w[3]};
        lo[63:32] = {w[4], w[5]};
        if (r >= 45) lo[31:0] = {w[6], w[7]};
      end
    end

    // Buffer size: mostly ample, often right at the fit boundary.
    n = 0;
    if (fam == FAM_V4 || fam == FAM_V6) begin
      build_text(fam, hi, lo);
      n = address_text.size();
    end
    r = $urandom_range(99);
    if (r < 55) size = 8'd255;
    else if (r < 80) size = 8'($urandom_range(n + 2, (n > 0) ? n - 1 : 0));
    else if (r < 90) size = 8'($urandom_range(255));
    else size = 8'($urandom_range(n));

    send_address(fam, hi, lo, size);
    predict_words(fam, hi, lo, size);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_stall <= 1'b1;
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check each accepted output word against the oldest expectation.
  always @(posedge clk) begin
    text_word_t want;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word %0d char %02h status %0d arrived with none expected",
                                  words_seen, text_char, status));
      end else begin
        want = expected_words.pop_front();
        if (text_char !== want.ch)
          report_mismatch($sformatf("word %0d char %02h, expected %02h",
                                    words_seen, text_char, want.ch));
        if (last !== want.last)
          report_mismatch($sformatf("word %0d last %0b, expected %0b",
                                    words_seen, last, want.last));
        if (status !== want.st)
          report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                    words_seen, status, want.st));
      end
    end
  end

  // Stimulus: directed table, then random addresses in three idling phases.
  initial begin
    address_row_t row;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_address(row.fam, row.hi, row.lo, row.size);
      if (!row.typed) begin
        predict_words(row.fam, row.hi, row.lo, row.size);
      end else if (row.st != ST_OK) begin
        push_word(8'h00, 1'b1, row.st);
      end else begin
        for (int k = 0; k < row.text.len(); k++)
          push_word(row.text[k], k == row.text.len() - 1, ST_OK);
      end
    end

    repeat (RANDOM_PER_PHASE) send_random_address();
    drain_words();

    send_idle_pct = 88;
    recv_idle_pct = 34;
    repeat (RANDOM_PER_PHASE) send_random_address();
    drain_words();

    // No idling; open with a long receiver hold-off so the input backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk);
    hold_requests = hold_requests + 1;
    repeat (PRESSURE_ITEMS) send_random_address();
    repeat (RANDOM_PER_PHASE - PRESSURE_ITEMS) send_random_address();
    drain_words();

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("ip_address_to_text_top regression: pass");
    end else begin
      $display("ip_address_to_text_top regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("ip_address_to_text_top regression: fail");
    $finish;
  end

endmodule

@@ ip_address_to_text_top.f @@
hw/rtl/ipat_pkg.sv
hw/rtl/ipat_char_unit.sv
hw/rtl/ip_address_to_text_top.sv
test/tb_top.sv
